### rtl/core/ldfe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ldfe_pkg - LED dimmer frame encoder package
// Shared types, command codes, frame constants and the slot store geometry.
// ============================================================================
package ldfe_pkg;

    // Number of lights held in the slot store (2..16)
    localparam int LIGHTS_PER_BOARD = 16;
    localparam int SLOT_IDX_W       = (LIGHTS_PER_BOARD > 1) ? $clog2(LIGHTS_PER_BOARD) : 1;
    localparam logic [4:0] LIGHTS_LIMIT = 5'(LIGHTS_PER_BOARD);

    // Level clamp
    localparam logic [11:0] LEVEL_MAX = 12'd4095;

    // Header function codes (low nibble of the header byte)
    localparam logic [3:0] FN_BLANK = 4'h1;
    localparam logic [3:0] FN_LEVEL = 4'h2;
    localparam logic [3:0] FN_PULSE = 4'h3;
    localparam logic [3:0] FN_LATCH = 4'h4;
    localparam logic [3:0] FN_EVERY = 4'h6;

    // Frame body lengths in bytes (CRC byte excluded)
    localparam logic [4:0] LEN_LEVEL = 5'd3;
    localparam logic [4:0] LEN_PULSE = 5'd4;
    localparam logic [4:0] LEN_LATCH = 5'd1;
    localparam logic [4:0] LEN_BLANK = 5'd2;
    localparam logic [4:0] LEN_EVERY = 5'd25;

    // CRC polynomial terms
    localparam logic [7:0] CRC_FB  = 8'h18;
    localparam logic [7:0] CRC_TOP = 8'h80;

    typedef enum logic [2:0] {
        CMD_SET_LEVEL = 3'd0,
        CMD_PULSE     = 3'd1,
        CMD_LOAD_SLOT = 3'd2,
        CMD_SEND_ALL  = 3'd3,
        CMD_LATCH     = 3'd4,
        CMD_BLANK     = 3'd5
    } t_cmd;

    // Input item
    typedef struct packed {
        logic [2:0]         command;
        logic [3:0]         board;
        logic [3:0]         light;
        logic signed [15:0] level;
        logic [7:0]         decay;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } t_out_item;

    // Slot store control
    typedef struct packed {
        logic        wr_en;
        logic        clr;
        logic [3:0]  wr_light;
        logic [11:0] wr_level;
    } t_store_ctl;

endpackage
`default_nettype wire

### rtl/core/led_dimmer_frame_encoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// led_dimmer_frame_encoder_unit - LED dimmer bus frame encoder
// Turns dimmer commands into CRC-terminated byte frames.
// ============================================================================
// One command is taken at a time. A frame command emits its bytes one per
// cycle through an output register while the output is not stalled, header
// first and the CRC byte last (with last set): latch 2 bytes, blank 3,
// set_level 4, pulse 5, send_all 26. The next command is taken in the cycle
// after the CRC byte is loaded. A single byte-wide CRC unit folds each
// byte as it is sent, and the slot store is read for two lights in every
// three body bytes while the send_all frame is packed. load_slot and unused
// command codes produce no frame and leave the unit idle. The input stalls
// while a frame is being sent.
module led_dimmer_frame_encoder_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    input  wire ldfe_pkg::t_in_item  i_in,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output ldfe_pkg::t_out_item      o_out,
    input  wire logic                i_out_stall
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SEND = 2'b10
    } t_state;

    t_state      r_state, n_state;
    logic [2:0]  r_cmd;
    logic [3:0]  r_hdr_fn;
    logic [3:0]  r_board;
    logic [3:0]  r_light;
    logic [11:0] r_lvl;
    logic [7:0]  r_decay;
    logic [4:0]  r_body_len;
    logic [4:0]  r_idx;
    logic [1:0]  r_phase;
    logic [3:0]  r_rd_light;
    logic [7:0]  r_save;
    logic [7:0]  r_crc;
    logic        r_out_valid;
    ldfe_pkg::t_out_item r_out;

    logic                 in_xfer;
    logic                 advance;
    logic                 at_crc;
    logic [11:0]          clamped;
    logic [11:0]          rd_level;
    logic [7:0]           cur_byte;
    logic [7:0]           crc_next;
    ldfe_pkg::t_store_ctl st_ctl;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign advance     = (r_state == S_SEND) && (!r_out_valid || !i_out_stall);
    assign at_crc      = (r_idx == r_body_len);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Level clamp to 0..4095
    always_comb begin
        if (i_in.level[15]) begin
            clamped = 12'd0;
        end else if (i_in.level[14:12] != 3'd0) begin
            clamped = ldfe_pkg::LEVEL_MAX;
        end else begin
            clamped = i_in.level[11:0];
        end
    end

    // Slot store control
    always_comb begin
        st_ctl.wr_en    = in_xfer && (i_in.command == ldfe_pkg::CMD_LOAD_SLOT);
        st_ctl.clr      = advance && at_crc && (r_cmd == ldfe_pkg::CMD_SEND_ALL);
        st_ctl.wr_light = i_in.light;
        st_ctl.wr_level = clamped;
    end

    ldfe_slot_store u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (st_ctl),
        .i_rd_light (r_rd_light),
        .o_rd_level (rd_level)
    );

    ldfe_crc8 u_crc (
        .i_crc  (r_crc),
        .i_byte (cur_byte),
        .o_crc  (crc_next)
    );

    // Body byte at the current index
    always_comb begin
        cur_byte = 8'h00;
        if (r_idx == 5'd0) begin
            cur_byte = {r_board, r_hdr_fn};
        end else if (r_cmd == ldfe_pkg::CMD_SEND_ALL) begin
            case (r_phase)
                2'd0:    cur_byte = rd_level[11:4];
                2'd1:    cur_byte = {r_save[3:0], rd_level[11:8]};
                default: cur_byte = r_save;
            endcase
        end else begin
            case (r_idx)
                5'd1:    cur_byte = (r_cmd == ldfe_pkg::CMD_BLANK) ? 8'h00
                                                                   : {r_light, r_lvl[11:8]};
                5'd2:    cur_byte = r_lvl[7:0];
                5'd3:    cur_byte = r_decay;
                default: cur_byte = 8'h00;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    case (i_in.command)
                        ldfe_pkg::CMD_SET_LEVEL,
                        ldfe_pkg::CMD_PULSE,
                        ldfe_pkg::CMD_SEND_ALL,
                        ldfe_pkg::CMD_LATCH,
                        ldfe_pkg::CMD_BLANK: n_state = S_SEND;
                        default:             n_state = S_IDLE;
                    endcase
                end
            end
            S_SEND: begin
                if (advance && at_crc) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Command capture
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_cmd   <= i_in.command;
            r_board <= i_in.board;
            r_light <= i_in.light;
            r_lvl   <= clamped;
            r_decay <= i_in.decay;
            case (i_in.command)
                ldfe_pkg::CMD_SET_LEVEL: begin
                    r_hdr_fn   <= ldfe_pkg::FN_LEVEL;
                    r_body_len <= ldfe_pkg::LEN_LEVEL;
                end
                ldfe_pkg::CMD_PULSE: begin
                    r_hdr_fn   <= ldfe_pkg::FN_PULSE;
                    r_body_len <= ldfe_pkg::LEN_PULSE;
                end
                ldfe_pkg::CMD_SEND_ALL: begin
                    r_hdr_fn   <= ldfe_pkg::FN_EVERY;
                    r_body_len <= ldfe_pkg::LEN_EVERY;
                end
                ldfe_pkg::CMD_LATCH: begin
                    r_hdr_fn   <= ldfe_pkg::FN_LATCH;
                    r_body_len <= ldfe_pkg::LEN_LATCH;
                end
                default: begin
                    r_hdr_fn   <= ldfe_pkg::FN_BLANK;
                    r_body_len <= ldfe_pkg::LEN_BLANK;
                end
            endcase
        end
    end

    // Byte counters, packing phase and CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_phase    <= '0;
            r_rd_light <= '0;
            r_crc      <= '0;
        end else if (in_xfer) begin
            r_idx      <= '0;
            r_phase    <= '0;
            r_rd_light <= '0;
            r_crc      <= '0;
        end else if (advance && !at_crc) begin
            r_idx <= r_idx + 5'd1;
            r_crc <= crc_next;
            if (r_idx != 5'd0 && r_cmd == ldfe_pkg::CMD_SEND_ALL) begin
                if (r_phase == 2'd2) begin
                    r_phase <= 2'd0;
                end else begin
                    r_phase    <= r_phase + 2'd1;
                    r_rd_light <= r_rd_light + 4'd1;
                end
            end
        end
    end

    // Held byte of the light pair being packed
    always_ff @(posedge i_clk) begin
        if (advance && r_idx != 5'd0 && r_phase != 2'd2) begin
            r_save <= rd_level[7:0];
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out.out_byte <= at_crc ? r_crc : cur_byte;
            r_out.last     <= at_crc;
        end
    end

    // Checks
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && at_crc) |=> (r_state == S_IDLE))
        else $error("sequencer did not return to idle after the CRC byte");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEND) |-> (r_idx <= r_body_len))
        else $error("byte index ran past the frame length");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_ctl.clr |-> (r_cmd == ldfe_pkg::CMD_SEND_ALL && r_state == S_SEND))
        else $error("slot store cleared outside a full-board frame");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !at_crc) |=> (r_out_valid && !r_out.last))
        else $error("body byte flagged as frame end");

endmodule
`default_nettype wire

### rtl/core/ldfe_crc8.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ldfe_crc8 - byte step of the reflected CRC-8
// Folds one byte, LSB first, into the running CRC value.
// ============================================================================
module ldfe_crc8 (
    input  wire logic [7:0] i_crc,
    input  wire logic [7:0] i_byte,
    output logic      [7:0] o_crc
);

    // Eight bit steps of the shift register
    always_comb begin
        logic [7:0] c;
        logic [7:0] b;
        c = i_crc;
        b = i_byte;
        for (int k = 0; k < 8; k++) begin
            if ((c[0] ^ b[0]) == 1'b1) begin
                c = ((c ^ ldfe_pkg::CRC_FB) >> 1) | ldfe_pkg::CRC_TOP;
            end else begin
                c = c >> 1;
            end
            b = b >> 1;
        end
        o_crc = c;
    end

endmodule
`default_nettype wire

### rtl/core/ldfe_slot_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ldfe_slot_store - per-light level store
// One 12-bit level per light; single write, single read, bulk clear.
// ============================================================================
module ldfe_slot_store (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire ldfe_pkg::t_store_ctl i_ctl,
    input  wire logic [3:0]           i_rd_light,
    output logic      [11:0]          o_rd_level
);

    logic [11:0] r_slot [ldfe_pkg::LIGHTS_PER_BOARD];
    logic        wr_hit;
    logic        rd_hit;

    assign wr_hit = ({1'b0, i_ctl.wr_light} < ldfe_pkg::LIGHTS_LIMIT);
    assign rd_hit = ({1'b0, i_rd_light} < ldfe_pkg::LIGHTS_LIMIT);

    // Storage: cleared on reset and after a full-board frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            for (int i = 0; i < ldfe_pkg::LIGHTS_PER_BOARD; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_ctl.wr_en && wr_hit) begin
            r_slot[i_ctl.wr_light[ldfe_pkg::SLOT_IDX_W-1:0]] <= i_ctl.wr_level;
        end
    end

    // Lights with no slot read as zero
    assign o_rd_level = rd_hit ? r_slot[i_rd_light[ldfe_pkg::SLOT_IDX_W-1:0]] : 12'd0;

endmodule
`default_nettype wire
